/* sv/token_record_deframer_unit_macros.svh */
// Assertion macros for the token record deframer.
// No dependencies; included by token_record_deframer_unit.sv.
`ifndef TOKEN_RECORD_DEFRAMER_UNIT_MACROS_SVH
`define TOKEN_RECORD_DEFRAMER_UNIT_MACROS_SVH

// same-cycle implication, checked while out of reset
`define TRD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked while out of reset
`define TRD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/trd_pkg.sv */
// Shared codes and types for the token record deframer.
// No dependencies.
package trd_pkg;

  localparam int unsigned LEN_W = 32;
  localparam int unsigned VAL_W = 64;

  typedef logic [1:0] phase_t;
  localparam phase_t PH_HEADER  = 2'd0;
  localparam phase_t PH_LENGTH  = 2'd1;
  localparam phase_t PH_VALUE   = 2'd2;
  localparam phase_t PH_PAYLOAD = 2'd3;

  typedef logic [2:0] tok_kind_t;
  localparam tok_kind_t TK_EOF     = 3'd0;
  localparam tok_kind_t TK_LITERAL = 3'd4;
  localparam tok_kind_t TK_PSYM    = 3'd5;
  localparam tok_kind_t TK_PCMD    = 3'd6;
  localparam tok_kind_t TK_BAD     = 3'd7;

  typedef logic [2:0] lit_kind_t;
  localparam lit_kind_t LK_NONE  = 3'd0;
  localparam lit_kind_t LK_TRUE  = 3'd1;
  localparam lit_kind_t LK_FALSE = 3'd2;
  localparam lit_kind_t LK_INT   = 3'd3;
  localparam lit_kind_t LK_FLOAT = 3'd4;
  localparam lit_kind_t LK_STR   = 3'd5;

  // header bits 5:3 literal subtypes
  typedef logic [2:0] lit_sub_t;
  localparam lit_sub_t LS_TRUE  = 3'd0;
  localparam lit_sub_t LS_FALSE = 3'd1;
  localparam lit_sub_t LS_INT   = 3'd2;
  localparam lit_sub_t LS_FLOAT = 3'd3;
  localparam lit_sub_t LS_STR   = 3'd4;

  // header bits 7:6 length codes
  typedef logic [1:0] len_code_t;
  localparam len_code_t LC_ONE  = 2'd0;
  localparam len_code_t LC_TWO  = 2'd1;
  localparam len_code_t LC_FOUR = 2'd2;
  localparam len_code_t LC_ZERO = 2'd3;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_BAD_TOK = 2'd1;
  localparam status_t ST_BAD_LIT = 2'd2;

  typedef struct packed {
    tok_kind_t         token_kind;
    lit_kind_t         literal_kind;
    status_t           status;
    logic              payload_valid;
    logic [7:0]        payload_byte;
    logic [LEN_W-1:0]  string_length;
    logic [VAL_W-1:0]  literal_value;
    logic              record_done;
  } result_t;

endpackage

/* sv/token_record_deframer_unit.sv */
// Token record deframer: one stream byte per beat in, at most one result beat out.
// A result is registered in the output register as its byte is accepted.
// One byte per cycle unless a held result stalls it; the register frees as it is taken.
// Reset (rst_n low, synchronous): parser waits for a header, output register empty.
// Depends on trd_pkg and token_record_deframer_unit_macros.svh.
`include "token_record_deframer_unit_macros.svh"

module token_record_deframer_unit
  import trd_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_byte_value,
  input  logic             in_data_ended,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [2:0]       out_token_kind,
  output logic [2:0]       out_literal_kind,
  output logic [1:0]       out_status,
  output logic             out_payload_valid,
  output logic [7:0]       out_payload_byte,
  output logic [LEN_W-1:0] out_string_length,
  output logic [VAL_W-1:0] out_literal_value,
  output logic             out_record_done
);

  phase_t                 phase_r, phase_nxt;
  tok_kind_t              kind_r, kind_nxt;
  lit_kind_t              lit_r, lit_nxt;
  logic [2:0]             cnt_r, cnt_nxt;
  logic [2:0]             need_r, need_nxt;
  logic [LEN_W-1:0]       len_acc_r, len_acc_nxt;
  logic [LENGTH_BITS-1:0] left_r, left_nxt;
  logic [VAL_W-1:0]       val_r, val_nxt;

  logic                   out_valid_r;
  result_t                res_r, res_nxt;
  logic                   res_fire;
  logic                   in_fire;
  logic                   go_header;

  logic [LEN_W-1:0]       acc_next;
  logic [LEN_W-1:0]       len_sat;
  logic [LENGTH_BITS-1:0] left_dec;
  logic [2:0]             cnt_inc;
  len_code_t              hdr_lc;
  lit_sub_t               hdr_sub;
  tok_kind_t              hdr_code;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  assign hdr_code = in_byte_value[2:0];
  assign hdr_sub  = in_byte_value[5:3];
  assign hdr_lc   = in_byte_value[7:6];
  assign cnt_inc  = cnt_r + 3'd1;
  assign left_dec = left_r - {{(LENGTH_BITS-1){1'b0}}, 1'b1};
  assign acc_next = len_acc_r | ({{(LEN_W-8){1'b0}}, in_byte_value} << {cnt_r[1:0], 3'b000});

  generate
    if (LENGTH_BITS < LEN_W) begin : g_sat
      assign len_sat = (|acc_next[LEN_W-1:LENGTH_BITS])
                     ? {{(LEN_W-LENGTH_BITS){1'b0}}, {LENGTH_BITS{1'b1}}} : acc_next;
    end else begin : g_nosat
      assign len_sat = acc_next;
    end
  endgenerate

  always_comb begin
    phase_nxt   = phase_r;
    kind_nxt    = kind_r;
    lit_nxt     = lit_r;
    cnt_nxt     = cnt_r;
    need_nxt    = need_r;
    len_acc_nxt = len_acc_r;
    left_nxt    = left_r;
    val_nxt     = val_r;
    res_nxt     = '0;
    res_fire    = 1'b0;
    go_header   = 1'b0;
    if (in_fire) begin
      if (in_data_ended) begin
        go_header           = 1'b1;
        kind_nxt            = TK_EOF;
        lit_nxt             = LK_NONE;
        res_fire            = 1'b1;
        res_nxt.token_kind  = TK_EOF;
        res_nxt.record_done = 1'b1;
      end else begin
        unique case (phase_r)
          PH_HEADER: begin
            kind_nxt = hdr_code;
            lit_nxt  = LK_NONE;
            if (hdr_code == TK_EOF || hdr_code == TK_PSYM || hdr_code == TK_PCMD) begin
              res_fire            = 1'b1;
              res_nxt.token_kind  = hdr_code;
              res_nxt.record_done = 1'b1;
            end else if (hdr_code == TK_BAD) begin
              kind_nxt            = TK_EOF;
              res_fire            = 1'b1;
              res_nxt.token_kind  = TK_EOF;
              res_nxt.status      = ST_BAD_TOK;
              res_nxt.record_done = 1'b1;
            end else if (hdr_code == TK_LITERAL &&
                         (hdr_sub == LS_TRUE || hdr_sub == LS_FALSE)) begin
              res_fire             = 1'b1;
              res_nxt.token_kind   = TK_LITERAL;
              res_nxt.literal_kind = (hdr_sub == LS_TRUE) ? LK_TRUE : LK_FALSE;
              res_nxt.record_done  = 1'b1;
            end else if (hdr_code == TK_LITERAL &&
                         (hdr_sub == LS_INT || hdr_sub == LS_FLOAT)) begin
              lit_nxt   = (hdr_sub == LS_INT) ? LK_INT : LK_FLOAT;
              phase_nxt = PH_VALUE;
              cnt_nxt   = 3'd0;
              val_nxt   = '0;
            end else if (hdr_code == TK_LITERAL && hdr_sub != LS_STR) begin
              res_fire            = 1'b1;
              res_nxt.token_kind  = TK_LITERAL;
              res_nxt.status      = ST_BAD_LIT;
              res_nxt.record_done = 1'b1;
            end else begin
              // string record: keyword, identifier, punctuation or string literal
              if (hdr_code == TK_LITERAL) begin
                lit_nxt = LK_STR;
              end
              cnt_nxt     = 3'd0;
              len_acc_nxt = '0;
              case (hdr_lc)
                LC_ONE:  need_nxt = 3'd1;
                LC_TWO:  need_nxt = 3'd2;
                LC_FOUR: need_nxt = 3'd4;
                default: need_nxt = need_r;
              endcase
              if (hdr_lc == LC_ZERO) begin
                res_fire             = 1'b1;
                res_nxt.token_kind   = hdr_code;
                res_nxt.literal_kind = (hdr_code == TK_LITERAL) ? LK_STR : LK_NONE;
                res_nxt.record_done  = 1'b1;
              end else begin
                phase_nxt = PH_LENGTH;
              end
            end
          end
          PH_LENGTH: begin
            len_acc_nxt = acc_next;
            cnt_nxt     = cnt_inc;
            if (cnt_inc >= need_r) begin
              cnt_nxt = 3'd0;
              if (len_sat == '0) begin
                go_header            = 1'b1;
                res_fire             = 1'b1;
                res_nxt.token_kind   = kind_r;
                res_nxt.literal_kind = lit_r;
                res_nxt.record_done  = 1'b1;
              end else begin
                len_acc_nxt = len_sat;
                left_nxt    = len_sat[LENGTH_BITS-1:0];
                phase_nxt   = PH_PAYLOAD;
              end
            end
          end
          PH_VALUE: begin
            val_nxt = val_r | ({{(VAL_W-8){1'b0}}, in_byte_value} << {cnt_r, 3'b000});
            cnt_nxt = cnt_inc;
            if (cnt_r == 3'd7) begin
              go_header             = 1'b1;
              res_fire              = 1'b1;
              res_nxt.token_kind    = TK_LITERAL;
              res_nxt.literal_kind  = lit_r;
              res_nxt.literal_value = val_nxt;
              res_nxt.record_done   = 1'b1;
            end
          end
          PH_PAYLOAD: begin
            left_nxt              = left_dec;
            res_fire              = 1'b1;
            res_nxt.token_kind    = kind_r;
            res_nxt.literal_kind  = lit_r;
            res_nxt.payload_valid = 1'b1;
            res_nxt.payload_byte  = in_byte_value;
            res_nxt.string_length = len_acc_r;
            res_nxt.record_done   = (left_dec == '0);
            go_header             = (left_dec == '0);
          end
          default: phase_nxt = PH_HEADER;
        endcase
      end
      if (go_header) begin
        phase_nxt   = PH_HEADER;
        cnt_nxt     = 3'd0;
        need_nxt    = 3'd0;
        len_acc_nxt = '0;
        left_nxt    = '0;
        val_nxt     = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEADER;
      kind_r      <= TK_EOF;
      lit_r       <= LK_NONE;
      cnt_r       <= 3'd0;
      need_r      <= 3'd0;
      len_acc_r   <= '0;
      left_r      <= '0;
      val_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      kind_r    <= kind_nxt;
      lit_r     <= lit_nxt;
      cnt_r     <= cnt_nxt;
      need_r    <= need_nxt;
      len_acc_r <= len_acc_nxt;
      left_r    <= left_nxt;
      val_r     <= val_nxt;
      if (in_ready) begin
        out_valid_r <= res_fire;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && res_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_token_kind    = res_r.token_kind;
  assign out_literal_kind  = res_r.literal_kind;
  assign out_status        = res_r.status;
  assign out_payload_valid = res_r.payload_valid;
  assign out_payload_byte  = res_r.payload_byte;
  assign out_string_length = res_r.string_length;
  assign out_literal_value = res_r.literal_value;
  assign out_record_done   = res_r.record_done;

  `TRD_ASSERT_NOW(a_payload_left_nz, phase_r == PH_PAYLOAD, left_r != '0, "payload phase with nothing left")
  `TRD_ASSERT_NEXT(a_end_gives_eof, in_fire && in_data_ended, out_valid_r && out_record_done && out_token_kind == TK_EOF && out_status == ST_OK, "end of data without eof record")
  `TRD_ASSERT_NOW(a_error_ends_record, out_valid_r && out_status != ST_OK, out_record_done && !out_payload_valid, "error result not closing its record")
  `TRD_ASSERT_NOW(a_payload_no_value, out_valid_r && out_payload_valid, out_literal_value == '0 && out_string_length != '0, "payload beat with bad side fields")

endmodule

/* test/trd_record_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for token_record_deframer_unit: follows the parser on each accepted
// input beat, queues the expected result beats and compares every output beat.
// Depends on trd_pkg.
module trd_record_checker
  import trd_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic [7:0]       in_byte_value,
  input  logic             in_data_ended,
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic [2:0]       out_token_kind,
  input  logic [2:0]       out_literal_kind,
  input  logic [1:0]       out_status,
  input  logic             out_payload_valid,
  input  logic [7:0]       out_payload_byte,
  input  logic [LEN_W-1:0] out_string_length,
  input  logic [VAL_W-1:0] out_literal_value,
  input  logic             out_record_done,
  output int unsigned      fail_count,
  output int unsigned      outstanding
);

  phase_t           ph;
  tok_kind_t        kind_q;
  lit_kind_t        lit_q;
  logic [2:0]       cnt;
  logic [2:0]       len_need;
  logic [LEN_W-1:0] len_acc;
  logic [LEN_W-1:0] pay_left;
  logic [VAL_W-1:0] val_acc;
  result_t          expected_records[$];

  task automatic return_to_header();
    ph       = PH_HEADER;
    cnt      = '0;
    len_need = '0;
    len_acc  = '0;
    pay_left = '0;
    val_acc  = '0;
  endtask

  // length code 11 means an empty string, reported at once
  task automatic open_string(input len_code_t lc, output logic zero_now);
    cnt      = '0;
    len_acc  = '0;
    zero_now = 1'b0;
    case (lc)
      LC_ONE:  len_need = 3'd1;
      LC_TWO:  len_need = 3'd2;
      LC_FOUR: len_need = 3'd4;
      default: zero_now = 1'b1;
    endcase
    if (!zero_now) ph = PH_LENGTH;
  endtask

  task automatic parse_stream_byte(input logic [7:0] b, input logic ended);
    result_t          r;
    logic             emit;
    tok_kind_t        code;
    logic [LEN_W-1:0] lim;
    r             = '0;
    r.record_done = 1'b1;
    emit          = 1'b0;
    code          = b[2:0];
    lim           = LEN_W'((64'd1 << LENGTH_BITS) - 64'd1);
    if (ended) begin
      return_to_header();
      kind_q = TK_EOF;
      lit_q  = LK_NONE;
      emit   = 1'b1;
    end else begin
      case (ph)
        PH_HEADER: begin
          kind_q       = code;
          lit_q        = LK_NONE;
          r.token_kind = code;
          emit         = 1'b1;
          if (code == TK_BAD) begin
            kind_q       = TK_EOF;
            r.token_kind = TK_EOF;
            r.status     = ST_BAD_TOK;
          end else if (code == TK_LITERAL) begin
            case (lit_sub_t'(b[5:3]))
              LS_TRUE:  r.literal_kind = LK_TRUE;
              LS_FALSE: r.literal_kind = LK_FALSE;
              LS_INT, LS_FLOAT: begin
                lit_q   = (lit_sub_t'(b[5:3]) == LS_INT) ? LK_INT : LK_FLOAT;
                ph      = PH_VALUE;
                cnt     = '0;
                val_acc = '0;
                emit    = 1'b0;
              end
              LS_STR: begin
                lit_q          = LK_STR;
                r.literal_kind = LK_STR;
                open_string(len_code_t'(b[7:6]), emit);
              end
              default: r.status = ST_BAD_LIT;
            endcase
          end else if (code != TK_EOF && code != TK_PSYM && code != TK_PCMD) begin
            open_string(len_code_t'(b[7:6]), emit);
          end
        end
        PH_VALUE: begin
          val_acc[8 * cnt +: 8] = b;
          cnt = cnt + 3'd1;
          if (cnt == 3'd0) begin
            r.token_kind    = TK_LITERAL;
            r.literal_kind  = lit_q;
            r.literal_value = val_acc;
            return_to_header();
            emit = 1'b1;
          end
        end
        PH_LENGTH: begin
          len_acc = len_acc | (LEN_W'(b) << (8 * cnt[1:0]));
          cnt     = cnt + 3'd1;
          if (cnt >= len_need) begin
            cnt = '0;
            if (len_acc > lim) len_acc = lim;
            if (len_acc == '0) begin
              r.token_kind   = kind_q;
              r.literal_kind = lit_q;
              return_to_header();
              emit = 1'b1;
            end else begin
              pay_left = len_acc;
              ph       = PH_PAYLOAD;
            end
          end
        end
        default: begin
          pay_left        = pay_left - LEN_W'(1);
          r.token_kind    = kind_q;
          r.literal_kind  = lit_q;
          r.payload_valid = 1'b1;
          r.payload_byte  = b;
          r.string_length = len_acc;
          r.record_done   = (pay_left == '0);
          if (r.record_done) return_to_header();
          emit = 1'b1;
        end
      endcase
    end
    if (emit) expected_records.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    if (!rst_n) begin
      return_to_header();
      kind_q = TK_EOF;
      lit_q  = LK_NONE;
      expected_records.delete();
      fail_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_records.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result beat: expected none, got kind %0h byte %0h",
                   $time, out_token_kind, out_payload_byte);
        end else begin
          want = expected_records.pop_front();
          check_field("token_kind", want.token_kind, out_token_kind);
          check_field("literal_kind", want.literal_kind, out_literal_kind);
          check_field("status", want.status, out_status);
          check_field("payload_valid", want.payload_valid, out_payload_valid);
          check_field("payload_byte", want.payload_byte, out_payload_byte);
          check_field("string_length", want.string_length, out_string_length);
          check_field("literal_value", want.literal_value, out_literal_value);
          check_field("record_done", want.record_done, out_record_done);
        end
      end
      if (in_valid && in_ready) parse_stream_byte(in_byte_value, in_data_ended);
    end
    outstanding <= expected_records.size();
  end

endmodule

/* test/tb_token_record_deframer_unit.sv */
`timescale 1ns / 1ps
// Testbench top for token_record_deframer_unit: drives directed and random token
// streams with bursty input and a stalling receiver, and gives the verdict.
// Depends on trd_pkg, token_record_deframer_unit and trd_record_checker.
module tb_token_record_deframer_unit;
  import trd_pkg::*;

  localparam int unsigned LEN_BITS     = 32;
  localparam int unsigned RANDOM_BEATS = 500;

  localparam tok_kind_t TK_KEYWORD = 3'd1;
  localparam tok_kind_t TK_IDENT   = 3'd2;
  localparam tok_kind_t TK_PUNCT   = 3'd3;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic [7:0]       in_byte_value;
  logic             in_data_ended;
  logic             out_valid;
  logic             out_ready;
  logic [2:0]       out_token_kind;
  logic [2:0]       out_literal_kind;
  logic [1:0]       out_status;
  logic             out_payload_valid;
  logic [7:0]       out_payload_byte;
  logic [LEN_W-1:0] out_string_length;
  logic [VAL_W-1:0] out_literal_value;
  logic             out_record_done;
  int unsigned      fail_count;
  int unsigned      outstanding;
  int unsigned      burst_left;
  int unsigned      beats_sent;

  token_record_deframer_unit #(
    .LENGTH_BITS(LEN_BITS)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte_value    (in_byte_value),
    .in_data_ended    (in_data_ended),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_token_kind   (out_token_kind),
    .out_literal_kind (out_literal_kind),
    .out_status       (out_status),
    .out_payload_valid(out_payload_valid),
    .out_payload_byte (out_payload_byte),
    .out_string_length(out_string_length),
    .out_literal_value(out_literal_value),
    .out_record_done  (out_record_done)
  );

  trd_record_checker #(
    .LENGTH_BITS(LEN_BITS)
  ) u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte_value    (in_byte_value),
    .in_data_ended    (in_data_ended),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_token_kind   (out_token_kind),
    .out_literal_kind (out_literal_kind),
    .out_status       (out_status),
    .out_payload_valid(out_payload_valid),
    .out_payload_byte (out_payload_byte),
    .out_string_length(out_string_length),
    .out_literal_value(out_literal_value),
    .out_record_done  (out_record_done),
    .fail_count       (fail_count),
    .outstanding      (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb_token_record_deframer_unit: done, errors");
    $finish;
  end

  // receiver: random stall stretches, with a long hold-off now and then
  initial begin : receiver
    int unsigned stretch;
    int unsigned mode;
    int unsigned run_len;
    out_ready = 1'b0;
    stretch   = 0;
    wait (rst_n === 1'b1);
    forever begin
      stretch++;
      if (stretch % 25 == 5) begin
        repeat (160) begin
          @(negedge clk);
          out_ready <= 1'b0;
        end
      end else begin
        mode    = $urandom_range(0, 2);
        run_len = $urandom_range(8, 48);
        repeat (run_len) begin
          @(negedge clk);
          case (mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= ($urandom_range(0, 3) != 0);
            default: out_ready <= 1'($urandom_range(0, 1));
          endcase
        end
      end
    end
  end

  task automatic send_beat(input logic [7:0] b, input logic ended);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 8);
    end
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_byte_value <= b;
    in_data_ended <= ended;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    beats_sent++;
  endtask

  task automatic send_end();
    send_beat(8'($urandom), 1'b1);
  endtask

  // header low bits, length code, length; stream ends early after cut payload beats
  task automatic send_string(input logic [5:0] hdr_low, input len_code_t lc,
                             input logic [31:0] len, input int unsigned cut);
    int unsigned nlen;
    logic [31:0] eff;
    send_beat({lc, hdr_low}, 1'b0);
    if (lc == LC_ZERO) return;
    nlen = (lc == LC_ONE) ? 1 : (lc == LC_TWO) ? 2 : 4;
    eff  = (lc == LC_ONE) ? {24'd0, len[7:0]} : (lc == LC_TWO) ? {16'd0, len[15:0]} : len;
    for (int i = 0; i < nlen; i++) send_beat(len[8 * i +: 8], 1'b0);
    for (int unsigned i = 0; i < eff && i < cut; i++) send_beat(8'($urandom), 1'b0);
    if (cut < eff) send_end();
  endtask

  task automatic send_value(input lit_sub_t sub, input logic [63:0] v,
                            input int unsigned nbytes);
    send_beat({2'($urandom), sub, TK_LITERAL}, 1'b0);
    for (int i = 0; i < nbytes; i++) send_beat(v[8 * i +: 8], 1'b0);
    if (nbytes < 8) send_end();
  endtask

  initial begin : stimulus
    int unsigned pick;
    int unsigned start_beats;
    tok_kind_t   kind;
    len_code_t   lc;
    logic [31:0] len;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_byte_value = '0;
    in_data_ended = 1'b0;
    burst_left    = 0;
    beats_sent    = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_end();
    send_beat({5'b11111, TK_EOF}, 1'b0);
    send_beat({5'($urandom), TK_PSYM}, 1'b0);
    send_beat({5'($urandom), TK_PCMD}, 1'b0);
    send_beat({5'b11111, TK_BAD}, 1'b0);
    send_beat({2'b00, LS_TRUE, TK_LITERAL}, 1'b0);
    send_beat({2'b11, LS_FALSE, TK_LITERAL}, 1'b0);
    for (int i = 1; i <= 3; i++) send_beat({2'($urandom), lit_sub_t'(LS_STR + i), TK_LITERAL}, 1'b0);
    send_value(LS_INT, '1, 8);
    send_string({3'b000, TK_KEYWORD}, LC_ZERO, '0, 0);
    send_string({3'b111, TK_IDENT}, LC_ONE, '0, 0);
    send_string({3'($urandom), TK_PUNCT}, LC_TWO, 32'd2, 2);
    send_string({LS_STR, TK_LITERAL}, LC_FOUR, '1, 1);

    start_beats = beats_sent;
    while (beats_sent - start_beats < RANDOM_BEATS) begin
      pick = $urandom_range(0, 99);
      kind = tok_kind_t'($urandom_range(TK_KEYWORD, TK_PUNCT));
      lc   = len_code_t'($urandom_range(LC_ONE, LC_ZERO));
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 10);
      if (pick < 30) begin
        send_string({3'($urandom), kind}, lc, len, len);
      end else if (pick < 44) begin
        send_string({LS_STR, TK_LITERAL}, lc, len, len);
      end else if (pick < 58) begin
        send_value(($urandom_range(0, 1) != 0) ? LS_INT : LS_FLOAT, {$urandom, $urandom}, 8);
      end else if (pick < 72) begin
        case ($urandom_range(0, 4))
          0:       send_beat({5'($urandom), TK_EOF}, 1'b0);
          1:       send_beat({5'($urandom), TK_PSYM}, 1'b0);
          2:       send_beat({5'($urandom), TK_PCMD}, 1'b0);
          3:       send_beat({2'($urandom), LS_TRUE, TK_LITERAL}, 1'b0);
          default: send_beat({2'($urandom), LS_FALSE, TK_LITERAL}, 1'b0);
        endcase
      end else if (pick < 82) begin
        if ($urandom_range(0, 1) != 0)
          send_beat({5'($urandom), TK_BAD}, 1'b0);
        else
          send_beat({2'($urandom), lit_sub_t'(LS_STR + $urandom_range(1, 3)), TK_LITERAL},
                    1'b0);
      end else if (pick < 92) begin
        // records cut short by the end of the data
        case ($urandom_range(0, 3))
          0: send_value(($urandom_range(0, 1) != 0) ? LS_INT : LS_FLOAT,
                        {$urandom, $urandom}, $urandom_range(0, 7));
          1: send_string({3'($urandom), kind}, len_code_t'($urandom_range(LC_ONE, LC_FOUR)),
                         $urandom, $urandom_range(0, 6));
          2: begin
            send_beat({LC_FOUR, 3'($urandom), kind}, 1'b0);
            repeat ($urandom_range(1, 3)) send_beat(8'($urandom), 1'b0);
            send_end();
          end
          default: send_end();
        endcase
      end else begin
        repeat ($urandom_range(1, 4)) send_beat(8'($urandom), 1'b0);
        send_end();
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb_token_record_deframer_unit: done, clean");
    end else begin
      $display("tb_token_record_deframer_unit: done, errors");
    end
    $finish;
  end

endmodule
